/* sv/json_number_scanner_macros.svh */
`ifndef JSON_NUMBER_SCANNER_MACROS_SVH
`define JSON_NUMBER_SCANNER_MACROS_SVH

// Checks the consequence in the same cycle as the antecedent.
`define JNS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Checks the consequence in the cycle after the antecedent.
`define JNS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* sv/jns_pkg.sv */
package jns_pkg;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_E_UP  = 8'h45;
    localparam logic [7:0] CH_E_LOW = 8'h65;

    localparam logic [63:0] MAG_LIMIT   = 64'h8000_0000_0000_0000;
    localparam logic [6:0]  LEN_OUT_MAX = 7'd127;

    localparam int Q_DEPTH = 2;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_INT,
        PH_FRAC,
        PH_EXP_SIGN,
        PH_EXP_DIGIT
    } t_phase;

    typedef enum logic [1:0] {
        ST_INT,
        ST_REAL,
        ST_SYNTAX,
        ST_RANGE
    } t_status;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       starts_token;
    } t_in_beat;

    typedef struct packed {
        t_status            status;
        logic signed [63:0] int_value;
        logic [6:0]         token_length;
    } t_out_beat;

    typedef struct packed {
        logic       start;
        logic       is_digit;
        logic [3:0] digit;
        logic       is_dot;
        logic       is_exp;
        logic       is_plus;
        logic       is_minus;
    } t_byte_class;

endpackage

/* sv/jns_front.sv */
module jns_front (
    input  logic                  i_valid,
    output logic                  o_stall,
    input  jns_pkg::t_in_beat     i_data,
    input  logic                  i_full,
    output logic                  o_push,
    output jns_pkg::t_byte_class  o_cls
);
    import jns_pkg::*;

    logic [7:0] w_diff;

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;
    assign w_diff  = i_data.text_byte - CH_ZERO;

    always_comb begin
        o_cls          = '0;
        o_cls.start    = i_data.starts_token;
        o_cls.is_digit = i_data.text_byte inside {[CH_ZERO:CH_NINE]};
        o_cls.digit    = w_diff[3:0];
        o_cls.is_dot   = (i_data.text_byte == CH_DOT);
        o_cls.is_exp   = i_data.text_byte inside {CH_E_LOW, CH_E_UP};
        o_cls.is_plus  = (i_data.text_byte == CH_PLUS);
        o_cls.is_minus = (i_data.text_byte == CH_MINUS);
    end

endmodule

/* sv/jns_queue.sv */
module jns_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  jns_pkg::t_byte_class  i_cls,
    output logic                  o_full,
    input  logic                  i_pop,
    output logic                  o_valid,
    output jns_pkg::t_byte_class  o_cls
);
    import jns_pkg::*;

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_byte_class r_mem [Q_DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;

    assign o_full  = (r_count == CW'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cls   = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PW'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cls;
        end
    end

endmodule

/* sv/jns_back.sv */
module jns_back #(
    parameter int MAX_TOKEN_LENGTH = 127
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  jns_pkg::t_byte_class  i_cls,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_stall,
    output jns_pkg::t_out_beat    o_data
);
    import jns_pkg::*;

    localparam int LW = $clog2(MAX_TOKEN_LENGTH + 1);
    localparam int EW = (LW > 7) ? LW : 7;

    t_phase        r_phase, n_phase, e_phase;
    logic          r_neg, n_neg, e_neg;
    logic          r_lz, n_lz, e_lz;
    logic [1:0]    r_icnt, n_icnt, e_icnt;
    logic          r_frac, n_frac, e_frac;
    logic          r_expd, n_expd, e_expd;
    logic          r_dec, n_dec, e_dec;
    logic [63:0]   r_mag, n_mag, e_mag;
    logic          r_ovf, n_ovf, e_ovf;
    logic [LW-1:0] r_len, n_len, e_len;
    logic          r_out_valid, n_out_valid;
    t_out_beat     r_out, n_out;

    logic          w_cont;
    logic          w_fire;
    logic          w_has_exp;
    logic [67:0]   w_acc;
    logic [EW-1:0] w_len_ext;

    assign o_pop   = i_valid && (!r_out_valid || !i_stall);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    assign w_acc = ({4'b0, e_mag} << 3) + ({4'b0, e_mag} << 1) + 68'(i_cls.digit);

    always_comb begin
        if (i_cls.start) begin
            e_phase = PH_INT;
            e_neg   = 1'b0;
            e_lz    = 1'b0;
            e_icnt  = '0;
            e_frac  = 1'b0;
            e_expd  = 1'b0;
            e_dec   = 1'b0;
            e_mag   = '0;
            e_ovf   = 1'b0;
            e_len   = '0;
        end else begin
            e_phase = r_phase;
            e_neg   = r_neg;
            e_lz    = r_lz;
            e_icnt  = r_icnt;
            e_frac  = r_frac;
            e_expd  = r_expd;
            e_dec   = r_dec;
            e_mag   = r_mag;
            e_ovf   = r_ovf;
            e_len   = r_len;
        end

        n_phase   = r_phase;
        n_neg     = r_neg;
        n_lz      = r_lz;
        n_icnt    = r_icnt;
        n_frac    = r_frac;
        n_expd    = r_expd;
        n_dec     = r_dec;
        n_mag     = r_mag;
        n_ovf     = r_ovf;
        n_len     = r_len;
        w_cont    = 1'b0;
        w_fire    = 1'b0;
        w_has_exp = (e_phase == PH_EXP_SIGN) || (e_phase == PH_EXP_DIGIT);
        w_len_ext = EW'(e_len);

        n_out              = r_out;
        n_out.status       = ST_INT;
        n_out.int_value    = '0;
        n_out.token_length = (w_len_ext > EW'(LEN_OUT_MAX)) ? LEN_OUT_MAX : w_len_ext[6:0];

        if (o_pop && (i_cls.start || r_phase != PH_IDLE)) begin
            n_phase = e_phase;
            n_neg   = e_neg;
            n_lz    = e_lz;
            n_icnt  = e_icnt;
            n_frac  = e_frac;
            n_expd  = e_expd;
            n_dec   = e_dec;
            n_mag   = e_mag;
            n_ovf   = e_ovf;
            n_len   = e_len;

            if (i_cls.start && i_cls.is_minus) begin
                n_neg  = 1'b1;
                w_cont = 1'b1;
            end else begin
                case (e_phase)
                    PH_INT: begin
                        if (i_cls.is_digit) begin
                            w_cont = 1'b1;
                            if (e_icnt == 2'd0 && i_cls.digit == 4'd0) begin
                                n_lz = 1'b1;
                            end
                            if (e_icnt != 2'd2) begin
                                n_icnt = e_icnt + 2'd1;
                            end
                            if (!e_ovf) begin
                                if (w_acc > {4'b0, MAG_LIMIT}) begin
                                    n_ovf = 1'b1;
                                end else begin
                                    n_mag = w_acc[63:0];
                                end
                            end
                        end else if (i_cls.is_dot) begin
                            w_cont  = 1'b1;
                            n_dec   = 1'b1;
                            n_phase = PH_FRAC;
                        end else if (i_cls.is_exp) begin
                            w_cont  = 1'b1;
                            n_phase = PH_EXP_SIGN;
                        end
                    end
                    PH_FRAC: begin
                        if (i_cls.is_digit) begin
                            w_cont = 1'b1;
                            n_frac = 1'b1;
                        end else if (i_cls.is_exp) begin
                            w_cont  = 1'b1;
                            n_phase = PH_EXP_SIGN;
                        end
                    end
                    PH_EXP_SIGN: begin
                        if (i_cls.is_plus || i_cls.is_minus) begin
                            w_cont  = 1'b1;
                            n_phase = PH_EXP_DIGIT;
                        end else if (i_cls.is_digit) begin
                            w_cont  = 1'b1;
                            n_expd  = 1'b1;
                            n_phase = PH_EXP_DIGIT;
                        end
                    end
                    PH_EXP_DIGIT: begin
                        if (i_cls.is_digit) begin
                            w_cont = 1'b1;
                            n_expd = 1'b1;
                        end
                    end
                    default: begin
                        w_cont = 1'b0;
                    end
                endcase
            end

            if (w_cont) begin
                if (e_len < LW'(MAX_TOKEN_LENGTH)) begin
                    n_len = e_len + 1'b1;
                end
            end else begin
                w_fire  = 1'b1;
                n_phase = PH_IDLE;
                if (e_icnt == 2'd0 || (e_lz && e_icnt > 2'd1) || (e_dec && !e_frac)
                        || (w_has_exp && !e_expd)) begin
                    n_out.status = ST_SYNTAX;
                end else if (e_dec || w_has_exp) begin
                    n_out.status = ST_REAL;
                end else if (e_ovf || (!e_neg && e_mag == MAG_LIMIT)) begin
                    n_out.status = ST_RANGE;
                end else begin
                    n_out.status    = ST_INT;
                    n_out.int_value = e_neg ? -$signed(e_mag) : $signed(e_mag);
                end
            end
        end

        if (w_fire) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_neg       <= 1'b0;
            r_lz        <= 1'b0;
            r_icnt      <= '0;
            r_frac      <= 1'b0;
            r_expd      <= 1'b0;
            r_dec       <= 1'b0;
            r_mag       <= '0;
            r_ovf       <= 1'b0;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_neg       <= n_neg;
            r_lz        <= n_lz;
            r_icnt      <= n_icnt;
            r_frac      <= n_frac;
            r_expd      <= n_expd;
            r_dec       <= n_dec;
            r_mag       <= n_mag;
            r_ovf       <= n_ovf;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= n_out;
        end
    end

endmodule

/* sv/json_number_scanner.sv */
// The input beat that ends a token is registered in the queue, and its result beat then in the output register.
// Throughput: one input beat per cycle while the queue is not full, set by the combinational times-ten accumulate.
// A two-entry queue lets input beats be taken while a result beat waits downstream.
// Reset (synchronous, active low) empties the queue, returns the scanner to idle
// and clears the output valid; the block is ready in the first cycle after reset.
module json_number_scanner #(
    parameter int MAX_TOKEN_LENGTH = 127
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  jns_pkg::t_in_beat   i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output jns_pkg::t_out_beat  o_data
);
    import jns_pkg::*;

    `include "json_number_scanner_macros.svh"

    logic        w_push;
    logic        w_full;
    logic        w_q_valid;
    logic        w_pop;
    t_byte_class w_push_cls;
    t_byte_class w_head_cls;

    jns_front u_front (
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_cls   (w_push_cls)
    );

    jns_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cls   (w_push_cls),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cls   (w_head_cls)
    );

    jns_back #(
        .MAX_TOKEN_LENGTH (MAX_TOKEN_LENGTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_cls   (w_head_cls),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    `JNS_ASSERT_NOW(a_value_zero, o_valid && o_data.status != ST_INT, o_data.int_value == 64'sd0, "nonzero value on a non-integer result")
    `JNS_ASSERT_NOW(a_pop_nonempty, w_pop, w_q_valid, "queue popped while empty")
    `JNS_ASSERT_NEXT(a_push_held, w_push && !w_pop, w_q_valid, "pushed beat missing from queue")

endmodule

/* tb/testbench.sv */
module testbench;
    import jns_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_BEATS   = 400;
    localparam int HOLD_CYCLES    = 120;
    localparam int HOLD_AFTER     = 250;

    typedef struct {
        t_in_beat beat;
        bit       drain;
    } t_pending;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_beat  i_data;
    logic      o_valid;
    logic      i_stall;
    t_out_beat o_data;

    json_number_scanner i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    t_pending  pending_bytes[$];
    t_out_beat expected_tokens[$];

    int errors       = 0;
    int beats_in     = 0;
    int tokens_out   = 0;
    int status_seen[4];
    int quiet_cycles = 0;
    int stim_count   = 0;
    bit drain_next   = 0;
    bit beat_taken   = 0;

    t_phase     sc_phase   = PH_IDLE;
    bit         sc_neg     = 0;
    bit         sc_lead0   = 0;
    logic [1:0] sc_int_cnt = '0;
    bit         sc_frac    = 0;
    bit         sc_exp     = 0;
    logic [63:0] sc_mag    = '0;
    bit         sc_ovf     = 0;
    logic [6:0] sc_len     = '0;
    bit         sc_dot     = 0;

    function automatic void clear_token();
        sc_neg     = 0;
        sc_lead0   = 0;
        sc_int_cnt = '0;
        sc_frac    = 0;
        sc_exp     = 0;
        sc_mag     = '0;
        sc_ovf     = 0;
        sc_len     = '0;
        sc_dot     = 0;
    endfunction

    function automatic void bump_length();
        if (sc_len < LEN_OUT_MAX) begin
            sc_len = sc_len + 7'd1;
        end
    endfunction

    // Returns 1 when the beat ends a token; the token's result is then in tok.
    function automatic bit scan_byte(input t_in_beat b, output t_out_beat tok);
        logic [7:0]  c;
        logic [63:0] dv;
        bit          is_dig;
        bit          cont;
        bit          has_exp;
        c      = b.text_byte;
        dv     = c - CH_ZERO;
        is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
        tok    = '0;
        cont   = 0;
        if (b.starts_token) begin
            clear_token();
            sc_phase = PH_INT;
            if (c == CH_MINUS) begin
                sc_neg = 1;
                bump_length();
                return 0;
            end
        end else if (sc_phase == PH_IDLE) begin
            return 0;
        end
        case (sc_phase)
            PH_INT: begin
                if (is_dig) begin
                    if (sc_int_cnt == 2'd0 && dv == 64'd0) sc_lead0 = 1;
                    if (sc_int_cnt < 2'd2) sc_int_cnt = sc_int_cnt + 2'd1;
                    if (!sc_ovf) begin
                        if (sc_mag > (MAG_LIMIT - dv) / 64'd10) sc_ovf = 1;
                        else sc_mag = sc_mag * 64'd10 + dv;
                    end
                    cont = 1;
                end else if (c == CH_DOT) begin
                    sc_dot   = 1;
                    sc_phase = PH_FRAC;
                    cont     = 1;
                end else if (c == CH_E_LOW || c == CH_E_UP) begin
                    sc_phase = PH_EXP_SIGN;
                    cont     = 1;
                end
            end
            PH_FRAC: begin
                if (is_dig) begin
                    sc_frac = 1;
                    cont    = 1;
                end else if (c == CH_E_LOW || c == CH_E_UP) begin
                    sc_phase = PH_EXP_SIGN;
                    cont     = 1;
                end
            end
            PH_EXP_SIGN: begin
                if (c == CH_PLUS || c == CH_MINUS) begin
                    sc_phase = PH_EXP_DIGIT;
                    cont     = 1;
                end else if (is_dig) begin
                    sc_exp   = 1;
                    sc_phase = PH_EXP_DIGIT;
                    cont     = 1;
                end
            end
            PH_EXP_DIGIT: begin
                if (is_dig) begin
                    sc_exp = 1;
                    cont   = 1;
                end
            end
            default: begin
                cont = 0;
            end
        endcase
        if (cont) begin
            bump_length();
            return 0;
        end
        has_exp = (sc_phase == PH_EXP_SIGN) || (sc_phase == PH_EXP_DIGIT);
        if (sc_int_cnt == 2'd0 || (sc_lead0 && sc_int_cnt > 2'd1)
                || (sc_dot && !sc_frac) || (has_exp && !sc_exp)) begin
            tok.status = ST_SYNTAX;
        end else if (sc_dot || has_exp) begin
            tok.status = ST_REAL;
        end else if (sc_ovf || (!sc_neg && sc_mag == MAG_LIMIT)) begin
            tok.status = ST_RANGE;
        end else begin
            tok.status    = ST_INT;
            tok.int_value = sc_neg ? -sc_mag : sc_mag;
        end
        tok.token_length = sc_len;
        sc_phase = PH_IDLE;
        return 1;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    task automatic push_byte(input logic [7:0] c, input bit st, input bit counted);
        t_pending p;
        p.beat.text_byte    = c;
        p.beat.starts_token = st;
        p.drain             = drain_next;
        drain_next          = 0;
        pending_bytes.push_back(p);
        if (counted) stim_count++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            push_byte(s[i], i == 0, 1);
        end
    endtask

    task automatic push_number();
        string near_max;
        string enders;
        int    n;
        int    r;
        bit    first;
        near_max = "922337203685477580";
        enders   = " ,]}";
        first    = 1;
        if ($urandom_range(0, 3) == 0) begin
            push_byte(CH_MINUS, 1, 1);
            first = 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            n = 0;
        end else if (r < 15) begin
            push_byte(CH_ZERO, first, 1);
            first = 0;
            n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
        end else if (r < 27) begin
            for (int i = 0; i < near_max.len(); i++) begin
                push_byte(near_max[i], first, 1);
                first = 0;
            end
            n = $urandom_range(1, 2);
        end else begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 21) : $urandom_range(1, 5);
        end
        for (int i = 0; i < n; i++) begin
            push_byte(CH_ZERO + 8'($urandom_range(0, 9)), first, 1);
            first = 0;
        end
        if ($urandom_range(0, 9) < 3) begin
            push_byte(CH_DOT, first, 1);
            first = 0;
            n = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 4);
            for (int i = 0; i < n; i++) begin
                push_byte(CH_ZERO + 8'($urandom_range(0, 9)), 0, 1);
            end
        end
        if ($urandom_range(0, 3) == 0) begin
            push_byte($urandom_range(0, 1) ? CH_E_UP : CH_E_LOW, first, 1);
            first = 0;
            r = $urandom_range(0, 2);
            if (r == 1) push_byte(CH_PLUS, 0, 1);
            if (r == 2) push_byte(CH_MINUS, 0, 1);
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++) begin
                push_byte(CH_ZERO + 8'($urandom_range(0, 9)), 0, 1);
            end
        end
        r = $urandom_range(0, 9);
        if (r == 1) push_byte(8'h00, first, 1);
        else if (r >= 2 && r <= 5) push_byte(enders[$urandom_range(0, 3)], first, 1);
        else if (r >= 6) push_byte(8'($urandom_range(0, 255)), first, 1);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Sender: offers the next pending beat, with random gaps between beats.
    int tx_gap    = 0;
    int tx_popped = 0;
    bit tx_quiet  = 0;

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || beat_taken) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_valid <= 1'b0;
                end else if (pending_bytes.size() == 0
                        || (pending_bytes[0].drain && expected_tokens.size() != 0)) begin
                    i_valid <= 1'b0;
                end else begin
                    i_data  <= pending_bytes[0].beat;
                    i_valid <= 1'b1;
                    pending_bytes.pop_front();
                    tx_popped++;
                    if (tx_popped % 90 == 0) tx_quiet = !tx_quiet;
                    tx_gap = tx_quiet ? 0 : idle_len();
                end
            end
        end
    end

    // Receiver: random stalls, quiet stretches, and one long hold-off.
    int rx_run    = 0;
    int rx_hold   = 0;
    int rx_cycles = 0;
    bit rx_held   = 0;
    bit rx_quiet  = 0;

    always @(negedge i_clk) begin
        int len;
        if (i_rst_n) begin
            rx_cycles++;
            if (rx_cycles % 250 == 0) rx_quiet = !rx_quiet;
            if (rx_hold > 0) begin
                rx_hold--;
                i_stall <= 1'b1;
            end else if (!rx_held && beats_in >= HOLD_AFTER) begin
                rx_held = 1;
                rx_hold = HOLD_CYCLES - 1;
                i_stall <= 1'b1;
            end else if (rx_run > 0) begin
                rx_run--;
                i_stall <= 1'b1;
            end else begin
                len = rx_quiet ? 0 : idle_len();
                if (len > 0) rx_run = len - 1;
                i_stall <= (len > 0);
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_beat pred;
        t_out_beat want;
        if (i_rst_n) begin
            beat_taken <= i_valid && !o_stall;
            if (i_valid && !o_stall) begin
                beats_in++;
                if (scan_byte(i_data, pred)) expected_tokens.push_back(pred);
            end
            if (o_valid && !i_stall) begin
                tokens_out++;
                if (expected_tokens.size() == 0) begin
                    errors++;
                    $display("%0t unexpected result: expected none, actual status %0d value %0d length %0d",
                             $time, o_data.status, o_data.int_value, o_data.token_length);
                end else begin
                    want = expected_tokens.pop_front();
                    status_seen[want.status]++;
                    if (o_data.status !== want.status) begin
                        errors++;
                        $display("%0t status mismatch: expected %0d actual %0d",
                                 $time, want.status, o_data.status);
                    end
                    if (o_data.int_value !== want.int_value) begin
                        errors++;
                        $display("%0t int_value mismatch: expected %0d actual %0d",
                                 $time, want.int_value, o_data.int_value);
                    end
                    if (o_data.token_length !== want.token_length) begin
                        errors++;
                        $display("%0t token_length mismatch: expected %0d actual %0d",
                                 $time, want.token_length, o_data.token_length);
                    end
                end
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t watchdog: no beat moved for %0d cycles", $time, quiet_cycles);
                $display("RESULT: ERROR");
                $finish;
            end
        end else begin
            beat_taken <= 1'b0;
        end
    end

    initial begin
        int dir_count;
        int tok_idx;
        int r;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_data  = '0;

        push_text("0 ");
        push_text("-0,");
        push_text("9223372036854775807 ");
        push_text("-9223372036854775808]");
        push_text("9223372036854775808 ");
        push_text("-99999999999999999999 ");
        push_text("007 ");
        push_text("- ");
        push_text("1. ");
        push_text("-12.50}");
        push_text("3e ");
        push_text("4E+ ");
        push_text("6.02E+23 ");
        push_text("1e-7,");
        push_text(".5 ");
        push_text("e5 ");
        push_text("x");
        push_byte(8'hFF, 0, 1);
        push_byte(CH_ZERO + 8'd7, 0, 1);
        push_text("12");
        push_text("345 ");
        push_text("8-");
        push_text("42");
        push_byte(8'h00, 0, 1);
        dir_count = stim_count;

        tok_idx = 0;
        while (stim_count < dir_count + RANDOM_BEATS) begin
            if (tok_idx == 10 || tok_idx == 30) drain_next = 1;
            r = $urandom_range(0, 99);
            if (tok_idx == 20) begin
                push_byte(CH_ZERO + 8'd1, 1, 1);
                repeat (140) push_byte(CH_ZERO + 8'($urandom_range(0, 9)), 0, 1);
                push_byte(8'h20, 0, 1);
            end else if (r < 80) begin
                push_number();
            end else if (r < 90) begin
                repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)), 0, 1);
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1);
                end
            end
            tok_idx++;
        end

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || i_valid) @(posedge i_clk);
        while (expected_tokens.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (expected_tokens.size() != 0) begin
            errors++;
            $display("%0t %0d expected results never arrived", $time, expected_tokens.size());
        end
        $display("Scanned %0d input beats into %0d token results, with one long receiver hold-off",
                 beats_in, tokens_out);
        $display("Results by status: %0d integer, %0d real, %0d syntax error, %0d out of range",
                 status_seen[ST_INT], status_seen[ST_REAL], status_seen[ST_SYNTAX],
                 status_seen[ST_RANGE]);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
